@@ rtl/core/dht_pkg.sv @@
package dht_pkg;

	localparam int KEY_W  = 31;
	localparam int PAY_W  = 16;
	localparam int CAP_W  = 11;
	localparam int SLOT_W = 10;
	localparam int CNT_W  = 11;
	localparam int CAP_RESET = 16;

	typedef enum logic [1:0] {
		ST_STORED  = 2'd0,
		ST_DROPPED = 2'd1,
		ST_LIMIT   = 2'd2
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} in_word_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [CAP_W-1:0]  table_size;
		logic [CNT_W-1:0]  entry_count;
	} out_word_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} slot_entry_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_GCLR,
		S_GRD,
		S_GWAIT,
		S_MB_GO,
		S_MB_WAIT,
		S_MS_GO,
		S_MS_WAIT,
		S_PRD,
		S_PCHK
	} fsm_t;

endpackage

@@ rtl/core/dht_rem.sv @@
module dht_rem import dht_pkg::*; #(
	parameter int SW = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] dividend,
	input  logic [SW-1:0]    divisor,
	output logic             done,
	output logic [SW-1:0]    rem
);
	localparam int CW = $clog2(KEY_W);

	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [KEY_W-1:0] dvd_q;
	logic [SW-1:0]    r_q;
	logic [SW-1:0]    d_q;
	logic [SW:0]      trial;
	logic [SW:0]      diff;

	// restoring division, one quotient bit per cycle
	assign trial = {r_q, dvd_q[KEY_W-1]};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(KEY_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			d_q   <= divisor;
			r_q   <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
			r_q   <= (trial >= {1'b0, d_q}) ? diff[SW-1:0] : trial[SW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = r_q;
endmodule

@@ rtl/core/dht_mem.sv @@
module dht_mem import dht_pkg::*; #(
	parameter int AW = 10
) (
	input  logic        clk,
	input  logic        we,
	input  logic [AW:0] waddr,
	input  slot_entry_t wdata,
	input  logic        re,
	input  logic [AW:0] raddr,
	output slot_entry_t rdata
);
	slot_entry_t mem [2**(AW+1)];
	slot_entry_t rd_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) rd_q <= mem[raddr];
	end

	assign rdata = rd_q;
endmodule

@@ rtl/core/double_hash_table_insert_unit.sv @@
// Per insert: two remainders on the shared divider (load, 31 shift steps, done), then
//   a registered table read and a check per probe (P probes); a drop comes after all
//   S probes. A new word is taken only in idle; busy stays high until the insert ends.
//   A doubling adds a clearing pass over the 2*S new slots plus a registered read per
//   old slot walked, with a full insert for each entry reinserted.
// Reset (arst_n low): table size 16, count 0, then a clearing pass over the table slots
//   with busy high. A capacity write starts the same pass.
//   Results are strobed for one cycle on done; the receiver cannot stall.
module double_hash_table_insert_unit import dht_pkg::*; #(
	parameter int MAX_SLOTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_word_t    req,
	output logic        done,
	output out_word_t   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int AW = $clog2(MAX_SLOTS);
	localparam int SW = $clog2(MAX_SLOTS + 1);
	localparam logic [SW-1:0] MAXS = SW'(MAX_SLOTS);
	localparam logic [SW-1:0] RST_SIZE = SW'((CAP_RESET > MAX_SLOTS) ? MAX_SLOTS : CAP_RESET);

	fsm_t state_q, state_d;

	// table state: two banks; a doubling rehashes from the old bank into the other
	logic             bank_q;
	logic [SW-1:0]    size_q;
	logic [SW-1:0]    old_size_q;
	logic [SW-1:0]    count_q;
	logic [CAP_W-1:0] cap_q;

	// working word and probe state
	logic [KEY_W-1:0] cur_key_q;
	logic [PAY_W-1:0] cur_pay_q;
	logic [KEY_W-1:0] in_key_q;
	logic [PAY_W-1:0] in_pay_q;
	logic             in_grow_q;
	logic [AW-1:0]    clr_q;
	logic [SW-1:0]    j_q;
	logic [SW-1:0]    i_q;
	logic [AW-1:0]    pos_q;
	logic [SW-1:0]    step_q;

	logic      done_q;
	out_word_t rsp_q;

	// config write
	logic             cfg_wr;
	logic [CAP_W-1:0] wval;
	logic [SW-1:0]    wsize;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
	assign wval   = pwdata[CAP_W-1:0];
	assign prdata = 32'(cap_q);

	always_comb begin
		if (wval < CAP_W'(3)) wsize = SW'(3);
		else if (32'(wval) > MAX_SLOTS) wsize = MAXS;
		else wsize = SW'(wval);
	end

	// shared remainder unit
	logic          rem_start;
	logic [SW-1:0] rem_div;
	logic          rem_done;
	logic [SW-1:0] rem_val;

	dht_rem #(.SW(SW)) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (cur_key_q),
		.divisor  (rem_div),
		.done     (rem_done),
		.rem      (rem_val)
	);

	// slot memory
	logic          mem_we, mem_re;
	logic [AW:0]   mem_waddr, mem_raddr;
	slot_entry_t   mem_wdata, mem_rdata;

	dht_mem #(.AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// load test: 4*count >= 3*size, and whether doubling would pass the limit
	logic need_grow, over_limit;
	assign need_grow  = ({2'b00, count_q} << 2) >= ({2'b00, size_q} + {1'b0, size_q, 1'b0});
	assign over_limit = ({1'b0, size_q} << 1) > {1'b0, MAXS};

	// next probe slot: pos + step is below 2*size, one subtract folds it
	logic [SW:0] pos_sum;
	assign pos_sum = SW'(pos_q) + {1'b0, step_q};

	logic probe_end, clr_end, walk_end;
	assign probe_end = (i_q == size_q);
	assign clr_end   = (clr_q == AW'(size_q - 1'b1));
	assign walk_end  = (j_q == old_size_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		rem_start = 1'b0;
		rem_div   = size_q;
		mem_we    = 1'b0;
		mem_waddr = {bank_q, pos_q};
		mem_wdata = '{valid: 1'b1, key: cur_key_q, payload: cur_pay_q};
		mem_re    = 1'b0;
		mem_raddr = {bank_q, pos_q};
		case (state_q)
			S_CLEAR, S_GCLR: begin
				mem_we    = 1'b1;
				mem_waddr = {bank_q, clr_q};
				mem_wdata = '0;
				if (clr_end) state_d = (state_q == S_CLEAR) ? S_IDLE : S_GRD;
			end
			S_IDLE: begin
				if (start) begin
					if (!need_grow) state_d = S_MB_GO;
					else if (!over_limit) state_d = S_GCLR;
				end
			end
			S_GRD: begin
				if (walk_end) state_d = S_MB_GO;
				else begin
					mem_re    = 1'b1;
					mem_raddr = {~bank_q, j_q[AW-1:0]};
					state_d   = S_GWAIT;
				end
			end
			S_GWAIT: state_d = mem_rdata.valid ? S_MB_GO : S_GRD;
			S_MB_GO: begin
				rem_start = 1'b1;
				state_d   = S_MB_WAIT;
			end
			S_MB_WAIT: if (rem_done) state_d = S_MS_GO;
			S_MS_GO: begin
				rem_start = 1'b1;
				rem_div   = size_q - SW'(2);
				state_d   = S_MS_WAIT;
			end
			S_MS_WAIT: if (rem_done) state_d = S_PRD;
			S_PRD: begin
				if (probe_end) state_d = in_grow_q ? S_GRD : S_IDLE;
				else begin
					mem_re  = 1'b1;
					state_d = S_PCHK;
				end
			end
			S_PCHK: begin
				if (!mem_rdata.valid) begin
					mem_we  = 1'b1;
					state_d = in_grow_q ? S_GRD : S_IDLE;
				end else state_d = S_PRD;
			end
			default: state_d = S_IDLE;
		endcase
		if (cfg_wr) state_d = S_CLEAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q    <= 1'b0;
			size_q    <= RST_SIZE;
			count_q   <= '0;
			cap_q     <= CAP_W'(CAP_RESET);
			clr_q     <= '0;
			in_grow_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr) begin
				cap_q   <= wval;
				size_q  <= wsize;
				count_q <= '0;
				clr_q   <= '0;
			end else begin
				case (state_q)
					S_CLEAR, S_GCLR: clr_q <= clr_q + 1'b1;
					S_IDLE: begin
						if (start && need_grow) begin
							if (over_limit) begin
								done_q <= 1'b1;
							end else begin
								bank_q  <= ~bank_q;
								size_q  <= size_q << 1;
								count_q <= '0;
								clr_q   <= '0;
							end
						end
					end
					S_GRD: if (!walk_end) in_grow_q <= 1'b1;
					    else in_grow_q <= 1'b0;
					S_PRD: if (probe_end && !in_grow_q) done_q <= 1'b1;
					S_PCHK: begin
						if (!mem_rdata.valid) begin
							count_q <= count_q + 1'b1;
							if (!in_grow_q) done_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				in_key_q   <= req.key;
				in_pay_q   <= req.payload;
				cur_key_q  <= req.key;
				cur_pay_q  <= req.payload;
				old_size_q <= size_q;
				j_q        <= '0;
				rsp_q      <= '{status: ST_LIMIT, slot: '0, table_size: CAP_W'(size_q),
				                entry_count: CNT_W'(count_q)};
			end
			S_GRD: begin
				if (walk_end) begin
					cur_key_q <= in_key_q;
					cur_pay_q <= in_pay_q;
				end
			end
			S_GWAIT: begin
				if (mem_rdata.valid) begin
					cur_key_q <= mem_rdata.key;
					cur_pay_q <= mem_rdata.payload;
				end else j_q <= j_q + 1'b1;
			end
			S_MB_WAIT: if (rem_done) pos_q <= rem_val[AW-1:0];
			S_MS_WAIT: begin
				if (rem_done) begin
					step_q <= rem_val + 1'b1;
					i_q    <= '0;
				end
			end
			S_PRD: begin
				if (probe_end) begin
					j_q   <= j_q + 1'b1;
					rsp_q <= '{status: ST_DROPPED, slot: '0, table_size: CAP_W'(size_q),
					           entry_count: CNT_W'(count_q)};
				end
			end
			S_PCHK: begin
				if (!mem_rdata.valid) begin
					j_q   <= j_q + 1'b1;
					rsp_q <= '{status: ST_STORED, slot: SLOT_W'(pos_q),
					           table_size: CAP_W'(size_q),
					           entry_count: CNT_W'(count_q + 1'b1)};
				end else begin
					pos_q <= (pos_sum >= {1'b0, size_q}) ? AW'(pos_sum - {1'b0, size_q})
					                                    : AW'(pos_sum);
					i_q   <= i_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;
endmodule

@@ rtl/core/dht_checker.sv @@
module dht_checker import dht_pkg::*; #(
	parameter int MAX_SLOTS = 1024
) (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input out_word_t rsp
);
	a_accept_follow: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done) else $error("accepted word left no trace");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_STORED |-> rsp.slot == '0) else $error("slot set on reject");

	a_stored_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == ST_STORED |-> rsp.entry_count != '0)
		else $error("stored word but count zero");

	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == ST_LIMIT |-> 2 * 32'(rsp.table_size) > MAX_SLOTS)
		else $error("limit status below limit");
endmodule

bind double_hash_table_insert_unit dht_checker #(.MAX_SLOTS(MAX_SLOTS)) u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

@@ tb/tb_double_hash_table_insert_unit.sv @@
module tb_double_hash_table_insert_unit;
	import dht_pkg::*;

	localparam int MAX_SLOTS = 1024;
	localparam logic [2:0] ADDR_CAPACITY = 3'd0;
	// no register here, a write must change nothing
	localparam logic [2:0] ADDR_UNUSED = 3'd4;
	// drain time after the last word; worst case is a full probe walk at 1024 slots
	localparam int DRAIN_CYCLES = 2500;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_word_t    req;
	logic        done;
	out_word_t   rsp;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	double_hash_table_insert_unit #(.MAX_SLOTS(MAX_SLOTS)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// ---------------------------------------------------------------
	// Shadow table: same slot layout as the block, updated per insert
	// ---------------------------------------------------------------
	bit          tbl_valid [MAX_SLOTS];
	logic [30:0] tbl_key   [MAX_SLOTS];
	logic [15:0] tbl_pay   [MAX_SLOTS];
	bit          old_valid [MAX_SLOTS];
	logic [30:0] old_key   [MAX_SLOTS];
	logic [15:0] old_pay   [MAX_SLOTS];
	int unsigned tbl_size;
	int unsigned tbl_count;

	out_word_t   pending_rsp [$];
	int          err_count;

	function automatic int unsigned clamp_capacity(logic [31:0] v);
		int unsigned c;
		c = v[CAP_W-1:0];
		if (c < 3) c = 3;
		if (c > MAX_SLOTS) c = MAX_SLOTS;
		return c;
	endfunction

	function automatic void clear_table(int unsigned size);
		for (int i = 0; i < MAX_SLOTS; i++) tbl_valid[i] = 1'b0;
		tbl_size  = size;
		tbl_count = 0;
	endfunction

	// double hashing: base = k mod S, stride = 1 + k mod (S-2); first empty slot wins
	function automatic bit probe_and_store(logic [30:0] k, logic [15:0] p, output int where);
		longint unsigned s, base, stride, pos;
		s      = tbl_size;
		base   = k % s;
		stride = 1 + k % (s - 2);
		where  = 0;
		for (longint unsigned i = 0; i < s; i++) begin
			pos = (base + i * stride) % s;
			if (!tbl_valid[pos]) begin
				tbl_valid[pos] = 1'b1;
				tbl_key[pos]   = k;
				tbl_pay[pos]   = p;
				tbl_count++;
				where = int'(pos);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// doubling: reinsert in old slot order; entries that find no slot are lost
	function automatic void double_table();
		int unsigned old_size;
		int          unused_slot;
		bit          ok;
		old_size  = tbl_size;
		old_valid = tbl_valid;
		old_key   = tbl_key;
		old_pay   = tbl_pay;
		clear_table(old_size * 2);
		for (int j = 0; j < old_size; j++)
			if (old_valid[j]) ok = probe_and_store(old_key[j], old_pay[j], unused_slot);
	endfunction

	function automatic out_word_t insert_outcome(in_word_t w);
		out_word_t r;
		int        where;
		r.status = ST_STORED;
		where    = 0;
		if (4 * tbl_count >= 3 * tbl_size) begin
			if (2 * tbl_size > MAX_SLOTS) r.status = ST_LIMIT;
			else double_table();
		end
		if (r.status == ST_STORED && !probe_and_store(w.key, w.payload, where)) begin
			r.status = ST_DROPPED;
			where    = 0;
		end
		r.slot        = where[SLOT_W-1:0];
		r.table_size  = tbl_size[CAP_W-1:0];
		r.entry_count = tbl_count[CNT_W-1:0];
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Clock, reset, timeout
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("[double_hash_table_insert_unit] ERROR");
		$finish;
	end

	// ---------------------------------------------------------------
	// Result checker: done is a one-cycle strobe, no back-pressure
	// ---------------------------------------------------------------
	task automatic report_mismatch(string what, longint got, longint want);
		err_count++;
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
	endtask

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected word, status", rsp.status, -1);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status != want.status)
					report_mismatch("status", rsp.status, want.status);
				if (rsp.slot != want.slot)
					report_mismatch("slot", rsp.slot, want.slot);
				if (rsp.table_size != want.table_size)
					report_mismatch("table_size", rsp.table_size, want.table_size);
				if (rsp.entry_count != want.entry_count)
					report_mismatch("entry_count", rsp.entry_count, want.entry_count);
			end
		end
	end

	// ---------------------------------------------------------------
	// Drivers; all run from a falling edge, busy is stable there
	// ---------------------------------------------------------------
	task automatic wait_drained();
		while (pending_rsp.size() != 0 || busy) @(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle; waits until the block is idle first
	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		start <= 1'b0;
		wait_drained();
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_CAPACITY) clear_table(clamp_capacity(data));
	endtask

	// wait out the gap with start low, then hold start until a falling edge sees busy low
	task automatic send_word(in_word_t w, int gap, bit use_typed, out_word_t typed);
		out_word_t predicted;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		req   <= w;
		while (busy) @(negedge clk);
		// accepted at the coming rising edge
		predicted = insert_outcome(w);
		pending_rsp.push_back(use_typed ? typed : predicted);
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------
	// Directed table: capacity writes and inserts, typed results where obvious
	// ---------------------------------------------------------------
	typedef struct {
		bit          is_cfg;
		logic [2:0]  addr;
		logic [31:0] data;
		in_word_t    w;
		bit          typed;
		out_word_t   want;
	} step_row_t;

	step_row_t directed[$] = '{
		// after reset: 16 slots
		'{0, 0, 0, '{31'd0, 16'd0},          1, '{ST_STORED, 10'd0, 11'd16, 11'd1}},
		'{0, 0, 0, '{31'h7FFF_FFFF, 16'hFFFF}, 1, '{ST_STORED, 10'd15, 11'd16, 11'd2}},
		'{0, 0, 0, '{31'd16, 16'd1},         0, '{ST_STORED, 10'd0, 11'd0, 11'd0}},
		'{0, 0, 0, '{31'd0, 16'h8000},       0, '{ST_STORED, 10'd0, 11'd0, 11'd0}},
		// 4 slots: odd keys step by 2 and see only half the table
		'{1, ADDR_CAPACITY, 32'd4, '{31'd0, 16'd0}, 0, '{ST_STORED, 10'd0, 11'd0, 11'd0}},
		'{0, 0, 0, '{31'd1, 16'h00FF},       1, '{ST_STORED, 10'd1, 11'd4, 11'd1}},
		'{0, 0, 0, '{31'd3, 16'hFF00},       1, '{ST_STORED, 10'd3, 11'd4, 11'd2}},
		'{0, 0, 0, '{31'd5, 16'h1234},       1, '{ST_DROPPED, 10'd0, 11'd4, 11'd2}},
		'{0, 0, 0, '{31'd2, 16'h5678},       0, '{ST_STORED, 10'd0, 11'd0, 11'd0}},
		// load reaches 3/4: doubles to 8 before this insert
		'{0, 0, 0, '{31'd9, 16'h9ABC},       0, '{ST_STORED, 10'd0, 11'd0, 11'd0}},
		// unmapped address: table kept
		'{1, ADDR_UNUSED, 32'd5, '{31'd0, 16'd0}, 0, '{ST_STORED, 10'd0, 11'd0, 11'd0}},
		'{0, 0, 0, '{31'd17, 16'h0001},      0, '{ST_STORED, 10'd0, 11'd0, 11'd0}},
		// below the floor: clamps to 3, stride always 1
		'{1, ADDR_CAPACITY, 32'd0, '{31'd0, 16'd0}, 0, '{ST_STORED, 10'd0, 11'd0, 11'd0}},
		'{0, 0, 0, '{31'h5555_5555, 16'hAAAA}, 0, '{ST_STORED, 10'd0, 11'd0, 11'd0}},
		'{0, 0, 0, '{31'h2AAA_AAAA, 16'h5555}, 0, '{ST_STORED, 10'd0, 11'd0, 11'd0}},
		'{0, 0, 0, '{31'd3, 16'd3},          0, '{ST_STORED, 10'd0, 11'd0, 11'd0}},
		'{0, 0, 0, '{31'd6, 16'd6},          0, '{ST_STORED, 10'd0, 11'd0, 11'd0}},
		'{0, 0, 0, '{31'd12, 16'd12},        0, '{ST_STORED, 10'd0, 11'd0, 11'd0}},
		// upper bits are outside the register: 0x7FF clamps to the maximum
		'{1, ADDR_CAPACITY, 32'hFFFF_FFFF, '{31'd0, 16'd0}, 0, '{ST_STORED, 10'd0, 11'd0, 11'd0}},
		'{0, 0, 0, '{31'h7FFF_FFFF, 16'd7},  1, '{ST_STORED, 10'd1023, 11'd1024, 11'd1}},
		'{0, 0, 0, '{31'd1023, 16'd9},       0, '{ST_STORED, 10'd0, 11'd0, 11'd0}}
	};

	// random phases: capacity word and word count; clamped values included
	logic [31:0] phase_cap   [11] = '{32'd16, 32'd3, 32'd0, 32'd5, 32'd4, 32'hFFFF_FFFF,
		32'd520, 32'd7, 32'd2047, 32'd1, 32'd100};
	int          phase_words [11] = '{200, 120, 60, 100, 80, 60, 420, 150, 40, 60, 110};
	// sender idle percentage per phase, cycling
	int          idle_pct    [4]  = '{0, 55, 0, 29};

	function automatic logic [30:0] pick_key(logic [30:0] prev);
		case ($urandom_range(0, 5))
			0:       return $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0;
			1:       return 31'($urandom_range(0, 63));
			2:       return prev; // duplicate keys are stored again
			3:       return prev + 31'($urandom_range(1, 8));
			default: return 31'($urandom);
		endcase
	endfunction

	initial begin
		in_word_t    w;
		logic [30:0] last_key;
		int          gap;
		int          pct;
		err_count = 0;
		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		clear_table(CAP_RESET);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part
		foreach (directed[i]) begin
			if (directed[i].is_cfg) write_reg(directed[i].addr, directed[i].data);
			else send_word(directed[i].w, 0, directed[i].typed, directed[i].want);
		end

		// random part
		last_key = '0;
		foreach (phase_cap[p]) begin
			write_reg(ADDR_CAPACITY, phase_cap[p]);
			pct = idle_pct[p % 4];
			for (int n = 0; n < phase_words[p]; n++) begin
				// one full drain mid-run, then resume
				if (p == 0 && n == phase_words[p] / 2) begin
					start <= 1'b0;
					wait_drained();
				end
				// runs of back-to-back words even in idling phases
				gap = ($urandom_range(1, 100) <= pct) ? $urandom_range(1, 6) : 0;
				w.key     = pick_key(last_key);
				w.payload = 16'($urandom);
				last_key  = w.key;
				send_word(w, gap, 1'b0, '0);
			end
		end
		start <= 1'b0;

		while (pending_rsp.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (err_count == 0 && pending_rsp.size() == 0) begin
			$display("[double_hash_table_insert_unit] OK");
		end else begin
			$display("[double_hash_table_insert_unit] ERROR");
		end
		$finish;
	end

endmodule

@@ double_hash_table_insert_unit.f @@
rtl/core/dht_pkg.sv
rtl/core/dht_rem.sv
rtl/core/dht_mem.sv
rtl/core/double_hash_table_insert_unit.sv
rtl/core/dht_checker.sv
tb/tb_double_hash_table_insert_unit.sv
